@@ rtl/e2r_pkg.sv @@
package e2r_pkg;

  localparam int unsigned CordicStages = 32;
  localparam int unsigned PhaseWidth   = 32;
  // x/y carry 32 fractional bits plus sign and growth headroom
  localparam int unsigned XyWidth      = 36;
  localparam logic signed [XyWidth-1:0] GainInv = 36'sd2608131496;

  // atan(2^-i), 2^32 units per full turn
  function automatic logic signed [PhaseWidth:0] atan_lut(input logic [4:0] idx);
    logic signed [PhaseWidth:0] v;
    unique case (idx)
      5'd0:  v = 33'sh020000000;
      5'd1:  v = 33'sh012E4051E;
      5'd2:  v = 33'sh009FB385B;
      5'd3:  v = 33'sh0051111D4;
      5'd4:  v = 33'sh0028B0D43;
      5'd5:  v = 33'sh00145D7E1;
      5'd6:  v = 33'sh000A2F61E;
      5'd7:  v = 33'sh000517C55;
      5'd8:  v = 33'sh00028BE53;
      5'd9:  v = 33'sh000145F2F;
      5'd10: v = 33'sh0000A2F98;
      5'd11: v = 33'sh0000517CC;
      5'd12: v = 33'sh000028BE6;
      5'd13: v = 33'sh0000145F3;
      5'd14: v = 33'sh00000A2FA;
      5'd15: v = 33'sh00000517D;
      5'd16: v = 33'sh0000028BE;
      5'd17: v = 33'sh00000145F;
      5'd18: v = 33'sh000000A30;
      5'd19: v = 33'sh000000518;
      5'd20: v = 33'sh00000028C;
      5'd21: v = 33'sh000000146;
      5'd22: v = 33'sh0000000A3;
      5'd23: v = 33'sh000000051;
      5'd24: v = 33'sh000000029;
      5'd25: v = 33'sh000000014;
      5'd26: v = 33'sh00000000A;
      5'd27: v = 33'sh000000005;
      5'd28: v = 33'sh000000003;
      5'd29: v = 33'sh000000001;
      5'd30: v = 33'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  // one CORDIC rotation triple travelling down the chain
  typedef struct packed {
    logic signed [XyWidth-1:0]  x;
    logic signed [XyWidth-1:0]  y;
    logic signed [PhaseWidth:0] z;
    logic                       neg;
  } rot_t;

endpackage

@@ rtl/euler_to_rotation_matrix.sv @@
// Rotation matrix R = Rz(yaw) * Ry(pitch) * Rx(roll) from three binary angles.
// Fully pipelined: one angle triple per cycle while the output is not stalled;
// results pass 1 entry stage, 32 CORDIC cells, 1 rounding stage and two
// product stages of two registers each. All stages advance together and hold
// while the output is stalled with a result waiting; entries are Q2.14
// saturated to [-1, 1].
module euler_to_rotation_matrix #(
  parameter int unsigned ANGLE_WIDTH    = 16,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic signed [ANGLE_WIDTH-1:0]     roll_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0]     pitch_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0]     yaw_angle_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic signed [COEF_FRAC_BITS+1:0]  row0_col0_o,
  output logic signed [COEF_FRAC_BITS+1:0]  row0_col1_o,
  output logic signed [COEF_FRAC_BITS+1:0]  row0_col2_o,
  output logic signed [COEF_FRAC_BITS+1:0]  row1_col0_o,
  output logic signed [COEF_FRAC_BITS+1:0]  row1_col1_o,
  output logic signed [COEF_FRAC_BITS+1:0]  row1_col2_o,
  output logic signed [COEF_FRAC_BITS+1:0]  row2_col0_o,
  output logic signed [COEF_FRAC_BITS+1:0]  row2_col1_o,
  output logic signed [COEF_FRAC_BITS+1:0]  row2_col2_o
);
  import e2r_pkg::*;

  localparam int unsigned CW = COEF_FRAC_BITS + 2;
  localparam int unsigned Depth = CordicStages + 6;
  localparam int unsigned RndSh = PhaseWidth - COEF_FRAC_BITS;
  localparam logic signed [XyWidth-1:0] RndHalf = XyWidth'(1) <<< (RndSh - 1);
  localparam logic signed [XyWidth-1:0] OneXy   = XyWidth'(1) <<< COEF_FRAC_BITS;
  localparam logic signed [PhaseWidth:0] Quarter = (PhaseWidth+1)'(1) <<< 30;
  localparam logic signed [PhaseWidth:0] HalfTurn = (PhaseWidth+1)'(1) <<< 31;

  logic [Depth-1:0] vld_q;
  logic en;

  // advance unless a finished result is stuck at the output
  assign en = !(vld_q[Depth-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  // entry stage: phase fold into [-pi/2, pi/2]
  logic [ANGLE_WIDTH-1:0] ang [3];
  rot_t [2:0] ent_d;
  rot_t [2:0] chain [CordicStages+1];

  assign ang[0] = roll_angle_i;
  assign ang[1] = pitch_angle_i;
  assign ang[2] = yaw_angle_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [PhaseWidth:0] z;
      z = (PhaseWidth+1)'($signed(ang[a])) <<< (PhaseWidth - ANGLE_WIDTH);
      ent_d[a].x = GainInv;
      ent_d[a].y = '0;
      ent_d[a].neg = 1'b0;
      if (z > Quarter) begin
        z = z - HalfTurn;
        ent_d[a].neg = 1'b1;
      end else if (z < -Quarter) begin
        z = z + HalfTurn;
        ent_d[a].neg = 1'b1;
      end
      ent_d[a].z = z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      chain[0] <= ent_d;
    end
  end

  for (genvar s = 0; s < CordicStages; s++) begin : g_cell
    e2r_cordic_cell #(.Stage(s)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .rot_i (chain[s]),
      .rot_o (chain[s+1])
    );
  end

  // round to coefficient precision: cos/sin of roll, pitch, yaw
  logic signed [CW-1:0] cs_d [6];
  logic signed [CW-1:0] cs_q [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      logic signed [XyWidth-1:0] v, r;
      v = (k % 2 == 0) ? chain[CordicStages][k/2].x : chain[CordicStages][k/2].y;
      if (chain[CordicStages][k/2].neg) begin
        v = -v;
      end
      r = (v + RndHalf) >>> RndSh;
      if (r > OneXy) begin
        cs_d[k] = CW'(OneXy);
      end else if (r < -OneXy) begin
        cs_d[k] = CW'(-OneXy);
      end else begin
        cs_d[k] = r[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_q <= cs_d;
    end
  end

  logic signed [CW-1:0] cr, sr, cp, sp, cy, sy;
  assign cr = cs_q[0];
  assign sr = cs_q[1];
  assign cp = cs_q[2];
  assign sp = cs_q[3];
  assign cy = cs_q[4];
  assign sy = cs_q[5];

  // Rz*Ry entries; the pass-through terms are delayed to match
  logic signed [CW-1:0] t00, t02, t10, t12;
  logic signed [CW-1:0] cr_d [2], sr_d [2], cp_d [2], sp_d [2], cy_d [2], sy_d [2];

  e2r_prod #(.CoefFrac(COEF_FRAC_BITS)) u_t00 (
    .clk_i(clk_i), .en_i(en), .a_i(cy), .b_i(cp), .c_i('0), .d_i('0), .res_o(t00));
  e2r_prod #(.CoefFrac(COEF_FRAC_BITS)) u_t02 (
    .clk_i(clk_i), .en_i(en), .a_i(cy), .b_i(sp), .c_i('0), .d_i('0), .res_o(t02));
  e2r_prod #(.CoefFrac(COEF_FRAC_BITS)) u_t10 (
    .clk_i(clk_i), .en_i(en), .a_i(sy), .b_i(cp), .c_i('0), .d_i('0), .res_o(t10));
  e2r_prod #(.CoefFrac(COEF_FRAC_BITS)) u_t12 (
    .clk_i(clk_i), .en_i(en), .a_i(sy), .b_i(sp), .c_i('0), .d_i('0), .res_o(t12));

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_d <= '{cr, cr_d[0]};
      sr_d <= '{sr, sr_d[0]};
      cp_d <= '{cp, cp_d[0]};
      sp_d <= '{sp, sp_d[0]};
      cy_d <= '{cy, cy_d[0]};
      sy_d <= '{sy, sy_d[0]};
    end
  end

  logic signed [CW-1:0] t01, t11, t20, t22, msr;
  assign t01 = -sy_d[1];
  assign t11 = cy_d[1];
  assign t20 = -sp_d[1];
  assign t22 = cp_d[1];
  assign msr = -sr_d[1];

  // R = T * Rx
  logic signed [CW-1:0] r01, r02, r11, r12, r21, r22;
  logic signed [CW-1:0] c0_d [2][3];

  e2r_prod #(.CoefFrac(COEF_FRAC_BITS)) u_r01 (
    .clk_i(clk_i), .en_i(en), .a_i(t01), .b_i(cr_d[1]), .c_i(t02), .d_i(sr_d[1]),
    .res_o(r01));
  e2r_prod #(.CoefFrac(COEF_FRAC_BITS)) u_r02 (
    .clk_i(clk_i), .en_i(en), .a_i(t01), .b_i(msr), .c_i(t02), .d_i(cr_d[1]),
    .res_o(r02));
  e2r_prod #(.CoefFrac(COEF_FRAC_BITS)) u_r11 (
    .clk_i(clk_i), .en_i(en), .a_i(t11), .b_i(cr_d[1]), .c_i(t12), .d_i(sr_d[1]),
    .res_o(r11));
  e2r_prod #(.CoefFrac(COEF_FRAC_BITS)) u_r12 (
    .clk_i(clk_i), .en_i(en), .a_i(t11), .b_i(msr), .c_i(t12), .d_i(cr_d[1]),
    .res_o(r12));
  e2r_prod #(.CoefFrac(COEF_FRAC_BITS)) u_r21 (
    .clk_i(clk_i), .en_i(en), .a_i('0), .b_i('0), .c_i(t22), .d_i(sr_d[1]),
    .res_o(r21));
  e2r_prod #(.CoefFrac(COEF_FRAC_BITS)) u_r22 (
    .clk_i(clk_i), .en_i(en), .a_i('0), .b_i('0), .c_i(t22), .d_i(cr_d[1]),
    .res_o(r22));

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_d[0] <= '{t00, t10, t20};
      c0_d[1] <= c0_d[0];
    end
  end

  assign row0_col0_o = c0_d[1][0];
  assign row1_col0_o = c0_d[1][1];
  assign row2_col0_o = c0_d[1][2];
  assign row0_col1_o = r01;
  assign row0_col2_o = r02;
  assign row1_col1_o = r11;
  assign row1_col2_o = r12;
  assign row2_col1_o = r21;
  assign row2_col2_o = r22;

endmodule

@@ rtl/e2r_cordic_cell.sv @@
module e2r_cordic_cell #(
  parameter int unsigned Stage = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  e2r_pkg::rot_t [2:0] rot_i,
  output e2r_pkg::rot_t [2:0] rot_o
);
  import e2r_pkg::*;

  localparam logic [4:0] StageIdx = 5'(Stage);

  rot_t [2:0] rot_d, rot_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rot_d[a].neg = rot_i[a].neg;
      if (!rot_i[a].z[PhaseWidth]) begin
        rot_d[a].x = rot_i[a].x - (rot_i[a].y >>> Stage);
        rot_d[a].y = rot_i[a].y + (rot_i[a].x >>> Stage);
        rot_d[a].z = rot_i[a].z - atan_lut(StageIdx);
      end else begin
        rot_d[a].x = rot_i[a].x + (rot_i[a].y >>> Stage);
        rot_d[a].y = rot_i[a].y - (rot_i[a].x >>> Stage);
        rot_d[a].z = rot_i[a].z + atan_lut(StageIdx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

@@ rtl/e2r_prod.sv @@
module e2r_prod #(
  parameter int unsigned CoefFrac = 14
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [CoefFrac+1:0] a_i,
  input  logic signed [CoefFrac+1:0] b_i,
  input  logic signed [CoefFrac+1:0] c_i,
  input  logic signed [CoefFrac+1:0] d_i,
  output logic signed [CoefFrac+1:0] res_o
);
  import e2r_pkg::*;

  localparam int unsigned SumW = 2 * CoefFrac + 6;
  localparam logic signed [SumW-1:0] Half = SumW'(1) <<< (CoefFrac - 1);
  localparam logic signed [SumW-1:0] One  = SumW'(1) <<< CoefFrac;

  logic signed [SumW-1:0] ab_q, cd_q, sum;
  logic signed [CoefFrac+1:0] res_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ab_q <= SumW'(a_i * b_i);
      cd_q <= SumW'(c_i * d_i);
    end
  end

  always_comb begin
    sum = (ab_q + cd_q + Half) >>> CoefFrac;
    if (sum > One) begin
      res_d = (CoefFrac+2)'(One);
    end else if (sum < -One) begin
      res_d = (CoefFrac+2)'(-One);
    end else begin
      res_d = sum[CoefFrac+1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule
